[rtl/core/tspd_pkg.sv]
// Shared types and constants for the transport stream PID filter and PES demultiplexer.
package tspd_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 188;

  localparam logic [7:0] SYNC_BYTE      = 8'h47;
  localparam logic [7:0] ST_AVC         = 8'h1b;
  localparam logic [7:0] ST_HEVC        = 8'h24;
  localparam logic [7:0] ST_AAC         = 8'h0f;
  localparam logic [7:0] SID_PADDING    = 8'hbe;
  localparam logic [7:0] SID_PSM        = 8'hbc;
  localparam logic [7:0] SID_PRIVATE2   = 8'hbf;
  localparam logic [7:0] SID_ECM        = 8'hf0;
  localparam logic [7:0] SID_EMM        = 8'hf1;
  localparam logic [7:0] SID_DIRECTORY  = 8'hff;
  localparam logic [15:0] WANTED_PROG_RST = 16'h0001;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SYNC      = 2'd1;
  localparam logic [1:0] ERR_TRANSPORT = 2'd2;
  localparam logic [1:0] ERR_PES_START = 2'd3;

  localparam logic KIND_ES    = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [3:0] {
    PH_NONE  = 4'b0001,
    PH_ALEN  = 4'b0010,
    PH_ASKIP = 4'b0100,
    PH_PAY   = 4'b1000
  } phase_e;

  typedef enum logic [4:0] {
    TGT_NONE = 5'b00001,
    TGT_PAT  = 5'b00010,
    TGT_PMT  = 5'b00100,
    TGT_VID  = 5'b01000,
    TGT_AUD  = 5'b10000
  } target_e;

  typedef enum logic [2:0] {
    PSI_POINTER = 3'b001,
    PSI_SKIP    = 3'b010,
    PSI_SECTION = 3'b100
  } psi_e;

  // 33-bit time stamp from its five coded bytes.
  function automatic logic [32:0] stamp(input logic [7:0] p0, input logic [7:0] p1,
                                        input logic [7:0] p2, input logic [7:0] p3,
                                        input logic [7:0] p4);
    stamp = {p0[3:1], p1, p2[7:1], p3, p4[7:1]};
  endfunction

endpackage

[rtl/core/ts_pid_filter_pes_demux.sv]
// Top level of the transport stream PID filter and PES demultiplexer.
// Takes one transport stream byte per cycle and gives at most one result item per byte:
// either an elementary stream byte tagged with its stream and time stamps, or an error
// item for a dropped packet. Each byte is parsed in the cycle it is accepted and its
// result lands in a single output register, so the block sustains one byte per clock;
// the input stalls only while that output register is full and stalled downstream.
module ts_pid_filter_pes_demux #(
  parameter int unsigned PACKET_BYTES = tspd_pkg::PACKET_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wanted_program_we_i,
  input  logic [15:0] wanted_program_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [1:0]  error_code_o,
  output logic        is_audio_o,
  output logic        unit_start_o,
  output logic [7:0]  es_byte_o,
  output logic [32:0] pts_o,
  output logic [32:0] dts_o,
  output logic        video_is_hevc_o
);
  import tspd_pkg::*;

  localparam int unsigned BODY_END = (PACKET_BYTES < 188) ? PACKET_BYTES : 188;

  logic [15:0] wanted_q;
  logic        locked_q, locked_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  hdr1_q, hdr1_d, hdr2_q, hdr2_d;
  logic [7:0]  skip_q, skip_d;
  logic [12:0] pmt_pid_q, pmt_pid_d, video_pid_q, video_pid_d, audio_pid_q, audio_pid_d;
  logic        pmt_valid_q, pmt_valid_d;
  logic [1:0]  pids_valid_q, pids_valid_d, codec_q, codec_d;
  logic [11:0] sec_cur_q, sec_cur_d, sec_len_q, sec_len_d, pil_q, pil_d;
  logic [31:0] sec_fields_q, sec_fields_d;
  logic [7:0]  pes_cur_q, pes_cur_d;
  logic [32:0] pts_v_q, pts_v_d, dts_v_q, dts_v_d, pts_a_q, pts_a_d, dts_a_q, dts_a_d;
  logic        pkt_drop_q, pkt_drop_d, pusi_q, pusi_d;
  phase_e      phase_q, phase_d;
  target_e     target_q, target_d;
  logic [1:0]  afc_q, afc_d;
  psi_e        psi_q, psi_d;
  logic        sec_ok_q, sec_ok_d, cur_next_q, cur_next_d;
  logic [15:0] entry_start_q, entry_start_d;
  logic [7:0]  entry_type_q, entry_type_d;
  logic        pes_hdr_q, pes_hdr_d, pes_drop_q, pes_drop_d, pes_special_q, pes_special_d;
  logic [8:0]  hdr_end_q, hdr_end_d;
  logic [1:0]  pes_flags_q, pes_flags_d;
  logic [7:0]  tbuf_q [10];
  logic [7:0]  tbuf_d [10];
  logic [1:0]  unit_ok_q, unit_ok_d, first_q, first_d;

  logic        res_valid;
  logic        res_kind, res_aud, res_us, res_hevc;
  logic [1:0]  res_err;
  logic [7:0]  res_byte;
  logic [32:0] res_pts, res_dts;

  logic        out_valid_q;
  logic        accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    logic [7:0]  b;
    logic [8:0]  pos_inc;
    logic [12:0] pid;
    logic        s;
    logic        payload_start;
    logic        adapt_done;
    logic [11:0] c;
    logic [15:0] i;
    logic [7:0]  pc;
    logic [8:0]  h;
    logic [32:0] pts_new;

    b = stream_byte_i;
    pos_inc = {1'b0, pos_q} + 9'd1;
    pid = '0;
    s = 1'b0;
    payload_start = 1'b0;
    adapt_done = 1'b0;
    c = sec_cur_q;
    i = '0;
    pc = pes_cur_q;
    h = '0;
    pts_new = '0;

    locked_d = locked_q; pos_d = pos_q; hdr1_d = hdr1_q; hdr2_d = hdr2_q; skip_d = skip_q;
    pmt_pid_d = pmt_pid_q; pmt_valid_d = pmt_valid_q; video_pid_d = video_pid_q;
    audio_pid_d = audio_pid_q; pids_valid_d = pids_valid_q; codec_d = codec_q;
    sec_cur_d = sec_cur_q; sec_len_d = sec_len_q; pil_d = pil_q; sec_fields_d = sec_fields_q;
    pes_cur_d = pes_cur_q; pts_v_d = pts_v_q; dts_v_d = dts_v_q; pts_a_d = pts_a_q;
    dts_a_d = dts_a_q; pkt_drop_d = pkt_drop_q; pusi_d = pusi_q; phase_d = phase_q;
    target_d = target_q; afc_d = afc_q; psi_d = psi_q; sec_ok_d = sec_ok_q;
    cur_next_d = cur_next_q; entry_start_d = entry_start_q; entry_type_d = entry_type_q;
    pes_hdr_d = pes_hdr_q; pes_drop_d = pes_drop_q; pes_special_d = pes_special_q;
    hdr_end_d = hdr_end_q; pes_flags_d = pes_flags_q; tbuf_d = tbuf_q;
    unit_ok_d = unit_ok_q; first_d = first_q;

    res_valid = 1'b0; res_kind = KIND_ES; res_err = ERR_NONE; res_aud = 1'b0;
    res_us = 1'b0; res_byte = '0; res_pts = '0; res_dts = '0; res_hevc = 1'b0;

    if (!locked_q) begin
      if (b == SYNC_BYTE) begin
        locked_d = 1'b1;
        pkt_drop_d = 1'b0;
        phase_d = PH_NONE;
        target_d = TGT_NONE;
        pos_d = 8'd1;
      end
    end else if (pos_q == 8'd0 && b != SYNC_BYTE) begin
      locked_d = 1'b0;
      res_valid = 1'b1;
      res_kind = KIND_ERROR;
      res_err = ERR_SYNC;
    end else begin
      if (pos_q == 8'd0) begin
        pkt_drop_d = 1'b0;
        phase_d = PH_NONE;
        target_d = TGT_NONE;
      end else if (pos_q < 8'd4) begin
        if (pos_q == 8'd1) begin
          hdr1_d = b;
          if (b[7]) begin
            pkt_drop_d = 1'b1;
            res_valid = 1'b1;
            res_kind = KIND_ERROR;
            res_err = ERR_TRANSPORT;
          end
        end
        if (pos_q == 8'd2) hdr2_d = b;
        if (pos_q == 8'd3) begin
          pid = {hdr1_q[4:0], hdr2_q};
          pusi_d = hdr1_q[6];
          afc_d = b[5:4];
          if (pid == 13'd0) target_d = TGT_PAT;
          else if (pmt_valid_q && pid == pmt_pid_q) target_d = TGT_PMT;
          else if (pids_valid_q[0] && pid == video_pid_q) target_d = TGT_VID;
          else if (pids_valid_q[1] && pid == audio_pid_q) target_d = TGT_AUD;
          else target_d = TGT_NONE;
          if (afc_d[1]) phase_d = PH_ALEN;
          else if (afc_d[0]) payload_start = 1'b1;
          else phase_d = PH_NONE;
        end
      end else if (!pkt_drop_q && {1'b0, pos_q} < 9'(BODY_END)) begin
        case (phase_q)
          PH_ALEN: begin
            skip_d = b;
            if (b == 8'd0) adapt_done = 1'b1;
            else phase_d = PH_ASKIP;
          end
          PH_ASKIP: begin
            skip_d = skip_q - 8'd1;
            if (skip_d == 8'd0) adapt_done = 1'b1;
          end
          PH_PAY: begin
            if ((target_q == TGT_PAT || target_q == TGT_PMT) && pusi_q) begin
              case (psi_q)
                PSI_POINTER: begin
                  skip_d = b;
                  psi_d = (b != 8'd0) ? PSI_SKIP : PSI_SECTION;
                  sec_cur_d = '0; sec_ok_d = 1'b1; sec_len_d = '0; cur_next_d = 1'b0;
                  pil_d = '0; entry_start_d = 16'hffff; sec_fields_d = '0;
                end
                PSI_SKIP: begin
                  skip_d = skip_q - 8'd1;
                  if (skip_d == 8'd0) psi_d = PSI_SECTION;
                end
                PSI_SECTION: begin
                  if (sec_ok_q) begin
                    if (c == 12'd1) begin
                      if (!b[7]) sec_ok_d = 1'b0;
                      sec_len_d = {b[3:0], 8'd0};
                    end else if (c == 12'd2) begin
                      sec_len_d = {sec_len_q[11:8], b};
                    end
                    if (target_q == TGT_PAT) begin
                      if (c == 12'd0 && b != 8'd0) sec_ok_d = 1'b0;
                      if (c == 12'd5) cur_next_d = b[0];
                      if (c >= 12'd8) begin
                        sec_fields_d = {sec_fields_q[23:0], b};
                        if (c[1:0] == 2'd3 && {1'b0, c} + 13'd2 <= {1'b0, sec_len_d}
                            && cur_next_d && sec_fields_d[31:16] == wanted_q) begin
                          pmt_pid_d = sec_fields_d[12:0];
                          pmt_valid_d = 1'b1;
                        end
                      end
                    end else begin
                      if (c == 12'd10) pil_d = {b[3:0], 8'd0};
                      if (c == 12'd11) begin
                        pil_d = {pil_q[11:8], b};
                        entry_start_d = 16'd12 + {4'd0, pil_d};
                      end
                      if (c >= 12'd12 && {4'd0, c} >= entry_start_d) begin
                        i = {4'd0, c} - entry_start_d;
                        if (i == 16'd0) begin
                          if ({1'b0, c} + 13'd6 > {1'b0, sec_len_d}) begin
                            sec_ok_d = 1'b0;
                          end else begin
                            entry_type_d = b;
                            sec_fields_d = '0;
                          end
                        end else begin
                          sec_fields_d = {sec_fields_q[23:0], b};
                        end
                        if (i == 16'd4) begin
                          pid = sec_fields_d[28:16];
                          if (entry_type_q == ST_AVC || entry_type_q == ST_HEVC) begin
                            video_pid_d = pid;
                            pids_valid_d[0] = 1'b1;
                            if (!codec_q[0]) codec_d = {entry_type_q == ST_HEVC, 1'b1};
                          end else if (entry_type_q == ST_AAC) begin
                            audio_pid_d = pid;
                            pids_valid_d[1] = 1'b1;
                          end
                          entry_start_d = {4'd0, c} + 16'd1 + {4'd0, sec_fields_d[11:0]};
                        end
                      end
                    end
                    if (c != 12'hfff) sec_cur_d = c + 12'd1;
                  end
                end
                default: ;
              endcase
            end else if ((target_q == TGT_VID || target_q == TGT_AUD) && !pes_drop_q) begin
              s = (target_q == TGT_AUD);
              if (pes_hdr_q) begin
                if ((pc < 8'd2 && b != 8'd0) || (pc == 8'd2 && b != 8'd1)) begin
                  pkt_drop_d = 1'b1;
                  res_valid = 1'b1;
                  res_kind = KIND_ERROR;
                  res_err = ERR_PES_START;
                  res_aud = s;
                end else if (pc == 8'd3 && b == SID_PADDING) begin
                  pes_drop_d = 1'b1;
                end else begin
                  if (pc == 8'd3 && (b == SID_PSM || b == SID_PRIVATE2 || b == SID_ECM
                      || b == SID_EMM || b == SID_DIRECTORY)) begin
                    pes_special_d = 1'b1;
                    hdr_end_d = 9'd6;
                  end
                  if (!pes_special_d) begin
                    if (pc == 8'd7) pes_flags_d = b[7:6];
                    if (pc == 8'd8) hdr_end_d = 9'd9 + {1'b0, b};
                    for (int k = 0; k < 10; k++) begin
                      if (pc == 8'(9 + k)) tbuf_d[k] = b;
                    end
                  end
                  if (hdr_end_d != 9'd0 && {1'b0, pc} + 9'd1 == hdr_end_d) begin
                    if (!pes_special_d) begin
                      h = hdr_end_d - 9'd9;
                      pts_new = s ? pts_a_q : pts_v_q;
                      if (pes_flags_d[1] && h >= 9'd5) begin
                        pts_new = stamp(tbuf_d[0], tbuf_d[1], tbuf_d[2], tbuf_d[3],
                                        tbuf_d[4]);
                      end
                      if (s) pts_a_d = pts_new; else pts_v_d = pts_new;
                      if (pes_flags_d[0]) begin
                        if (h >= 9'd10) begin
                          if (s) begin
                            dts_a_d = stamp(tbuf_d[5], tbuf_d[6], tbuf_d[7], tbuf_d[8],
                                            tbuf_d[9]);
                          end else begin
                            dts_v_d = stamp(tbuf_d[5], tbuf_d[6], tbuf_d[7], tbuf_d[8],
                                            tbuf_d[9]);
                          end
                        end
                      end else begin
                        if (s) dts_a_d = pts_new; else dts_v_d = pts_new;
                      end
                    end
                    unit_ok_d[s] = 1'b1;
                    first_d[s] = 1'b1;
                    pes_hdr_d = 1'b0;
                  end
                  if (pc != 8'hff) pes_cur_d = pc + 8'd1;
                end
              end else if (unit_ok_q[s]) begin
                res_valid = 1'b1;
                res_aud = s;
                res_us = first_q[s];
                res_byte = b;
                res_pts = s ? pts_a_q : pts_v_q;
                res_dts = s ? dts_a_q : dts_v_q;
                res_hevc = codec_q[1];
                first_d[s] = 1'b0;
              end
            end
          end
          default: ;
        endcase
        if (adapt_done) begin
          if (afc_q[0]) payload_start = 1'b1;
          else phase_d = PH_NONE;
        end
      end

      // Entering the payload resets the per-packet section and PES header parsers.
      if (payload_start) begin
        phase_d = PH_PAY;
        psi_d = PSI_POINTER;
        pes_drop_d = 1'b0;
        pes_hdr_d = pusi_d;
        pes_cur_d = '0;
        hdr_end_d = '0;
        pes_special_d = 1'b0;
        if (pusi_d && target_d == TGT_VID) unit_ok_d[0] = 1'b0;
        if (pusi_d && target_d == TGT_AUD) unit_ok_d[1] = 1'b0;
      end

      pos_d = (pos_inc >= 9'(PACKET_BYTES)) ? 8'd0 : pos_inc[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= WANTED_PROG_RST;
      locked_q <= 1'b0; pos_q <= '0; hdr1_q <= '0; hdr2_q <= '0; skip_q <= '0;
      pmt_pid_q <= '0; pmt_valid_q <= 1'b0; video_pid_q <= '0; audio_pid_q <= '0;
      pids_valid_q <= '0; codec_q <= '0; sec_cur_q <= '0; sec_len_q <= '0; pil_q <= '0;
      sec_fields_q <= '0; pes_cur_q <= '0; pts_v_q <= '0; dts_v_q <= '0; pts_a_q <= '0;
      dts_a_q <= '0; pkt_drop_q <= 1'b0; pusi_q <= 1'b0; phase_q <= PH_NONE;
      target_q <= TGT_NONE; afc_q <= '0; psi_q <= PSI_POINTER; sec_ok_q <= 1'b0;
      cur_next_q <= 1'b0; entry_start_q <= '0; entry_type_q <= '0; pes_hdr_q <= 1'b0;
      pes_drop_q <= 1'b0; pes_special_q <= 1'b0; hdr_end_q <= '0; pes_flags_q <= '0;
      for (int k = 0; k < 10; k++) tbuf_q[k] <= '0;
      unit_ok_q <= '0; first_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wanted_program_we_i) wanted_q <= wanted_program_i;
      if (accept) begin
        locked_q <= locked_d; pos_q <= pos_d; hdr1_q <= hdr1_d; hdr2_q <= hdr2_d;
        skip_q <= skip_d; pmt_pid_q <= pmt_pid_d; pmt_valid_q <= pmt_valid_d;
        video_pid_q <= video_pid_d; audio_pid_q <= audio_pid_d;
        pids_valid_q <= pids_valid_d; codec_q <= codec_d; sec_cur_q <= sec_cur_d;
        sec_len_q <= sec_len_d; pil_q <= pil_d; sec_fields_q <= sec_fields_d;
        pes_cur_q <= pes_cur_d; pts_v_q <= pts_v_d; dts_v_q <= dts_v_d;
        pts_a_q <= pts_a_d; dts_a_q <= dts_a_d; pkt_drop_q <= pkt_drop_d;
        pusi_q <= pusi_d; phase_q <= phase_d; target_q <= target_d; afc_q <= afc_d;
        psi_q <= psi_d; sec_ok_q <= sec_ok_d; cur_next_q <= cur_next_d;
        entry_start_q <= entry_start_d; entry_type_q <= entry_type_d;
        pes_hdr_q <= pes_hdr_d; pes_drop_q <= pes_drop_d; pes_special_q <= pes_special_d;
        hdr_end_q <= hdr_end_d; pes_flags_q <= pes_flags_d; tbuf_q <= tbuf_d;
        unit_ok_q <= unit_ok_d; first_q <= first_d;
      end
      if (accept && res_valid) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_o <= res_kind;
      error_code_o <= res_err;
      is_audio_o <= res_aud;
      unit_start_o <= res_us;
      es_byte_o <= res_byte;
      pts_o <= res_pts;
      dts_o <= res_dts;
      video_is_hevc_o <= res_hevc;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[dv/ts_pid_filter_pes_demux_tb.sv]
// Self-checking testbench for the transport stream PID filter and PES demultiplexer.
`timescale 1ns / 100ps

module ts_pid_filter_pes_demux_tb;
  import tspd_pkg::*;

  localparam int unsigned PKT_LEN = 188;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic        kind;
    logic [1:0]  err;
    logic        aud;
    logic        first;
    logic [7:0]  data;
    logic [32:0] pts;
    logic [32:0] dts;
    logic        hevc;
  } demux_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        wanted_program_we_i = 1'b0;
  logic [15:0] wanted_program_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [1:0]  error_code_o;
  logic        is_audio_o;
  logic        unit_start_o;
  logic [7:0]  es_byte_o;
  logic [32:0] pts_o;
  logic [32:0] dts_o;
  logic        video_is_hevc_o;

  ts_pid_filter_pes_demux dut (
    .clk_i, .rst_ni, .wanted_program_we_i, .wanted_program_i,
    .in_valid_i, .in_stall_o, .stream_byte_i,
    .out_valid_o, .out_stall_i, .kind_o, .error_code_o, .is_audio_o,
    .unit_start_o, .es_byte_o, .pts_o, .dts_o, .video_is_hevc_o
  );

  always #5 clk_i = ~clk_i;

  demux_out_t  pending_out_q[$];
  int unsigned fail_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  // Demultiplexer state as predicted from the byte stream.
  logic [15:0] m_want;
  bit          m_locked, m_drop, m_pusi, m_pmt_ok;
  int unsigned m_pos, m_sec_cur, m_pes_cur, m_hdr_end, m_sec_len, m_pil, m_ent_start;
  int unsigned m_sec_ok, m_cur_next;
  logic [31:0] m_hdr, m_fields;
  logic [7:0]  m_skip, m_ent_type;
  logic [12:0] m_pmt_pid, m_vid_pid, m_aud_pid;
  logic [1:0]  m_pid_ok, m_codec, m_afc, m_pes_flags;
  logic [32:0] m_pts [2];
  logic [32:0] m_dts [2];
  logic [7:0]  m_tbuf [10];
  bit          m_unit_ok [2];
  bit          m_first [2];
  bit          m_pes_hdr, m_pes_drop, m_pes_special;
  phase_e      m_phase;
  target_e     m_tgt;
  psi_e        m_psi;

  // Packet fields chosen by the stimulus.
  logic [12:0] s_pmt_pid, s_vid_pid, s_aud_pid;
  logic [3:0]  s_cc = '0;
  logic [7:0]  pkt_q[$];

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void model_reset();
    m_want = WANTED_PROG_RST;
    m_locked = 0; m_drop = 0; m_pusi = 0; m_pmt_ok = 0;
    m_pos = 0; m_sec_cur = 0; m_pes_cur = 0; m_hdr_end = 0; m_sec_len = 0;
    m_pil = 0; m_ent_start = 0; m_sec_ok = 0; m_cur_next = 0;
    m_hdr = '0; m_fields = '0; m_skip = '0; m_ent_type = '0;
    m_pmt_pid = '0; m_vid_pid = '0; m_aud_pid = '0; m_pid_ok = '0; m_codec = '0;
    m_afc = '0; m_pes_flags = '0;
    for (int i = 0; i < 2; i++) begin
      m_pts[i] = '0; m_dts[i] = '0; m_unit_ok[i] = 0; m_first[i] = 0;
    end
    for (int i = 0; i < 10; i++) m_tbuf[i] = '0;
    m_pes_hdr = 0; m_pes_drop = 0; m_pes_special = 0;
    m_phase = PH_NONE; m_tgt = TGT_NONE; m_psi = PSI_POINTER;
  endfunction

  function automatic void push_result(logic kind, logic [1:0] err, logic aud, logic first,
                                      logic [7:0] data, logic [32:0] pts, logic [32:0] dts,
                                      logic hevc);
    demux_out_t r;
    r = '{kind, err, aud, first, data, pts, dts, hevc};
    pending_out_q.insert(pending_out_q.size(), r);
  endfunction

  // Appends one byte to the packet under construction.
  function automatic void add_byte(logic [7:0] b);
    pkt_q.insert(pkt_q.size(), b);
  endfunction

  function automatic logic [32:0] decode_stamp(int unsigned at);
    logic [32:0] v;
    v = {30'd0, m_tbuf[at][3:1]};
    v = (v << 8) | 33'(m_tbuf[at + 1]);
    v = (v << 7) | 33'(m_tbuf[at + 2] >> 1);
    v = (v << 8) | 33'(m_tbuf[at + 3]);
    v = (v << 7) | 33'(m_tbuf[at + 4] >> 1);
    return v;
  endfunction

  function automatic void open_payload();
    m_phase = PH_PAY;
    m_psi = PSI_POINTER;
    m_pes_drop = 0;
    m_pes_hdr = m_pusi;
    m_pes_cur = 0;
    m_hdr_end = 0;
    m_pes_special = 0;
    if (m_pusi && (m_tgt == TGT_VID || m_tgt == TGT_AUD)) m_unit_ok[m_tgt == TGT_AUD] = 0;
  endfunction

  function automatic void section_model(logic [7:0] b);
    int unsigned c, i;
    logic [12:0] pid;
    c = m_sec_cur;
    if (c == 1) begin
      if (!b[7]) m_sec_ok = 0;
      m_sec_len = int'(b[3:0]) << 8;
    end else if (c == 2) begin
      m_sec_len = m_sec_len | int'(b);
    end
    if (m_tgt == TGT_PAT) begin
      if (c == 0 && b != 0) m_sec_ok = 0;
      if (c == 5) m_cur_next = b[0];
      if (c >= 8) begin
        m_fields = {m_fields[23:0], b};
        if (((c - 8) & 3) == 3 && c + 2 <= m_sec_len && m_cur_next != 0 &&
            m_fields[31:16] == m_want) begin
          m_pmt_pid = m_fields[12:0];
          m_pmt_ok = 1;
        end
      end
      return;
    end
    if (c == 10) m_pil = int'(b[3:0]) << 8;
    if (c == 11) begin
      m_pil = m_pil | int'(b);
      m_ent_start = 12 + m_pil;
    end
    if (c >= 12 && c >= m_ent_start) begin
      i = c - m_ent_start;
      if (i == 0) begin
        if (c + 6 > m_sec_len) begin
          m_sec_ok = 0;
          return;
        end
        m_ent_type = b;
        m_fields = '0;
      end else begin
        m_fields = {m_fields[23:0], b};
      end
      if (i == 4) begin
        pid = m_fields[28:16];
        if (m_ent_type == ST_AVC || m_ent_type == ST_HEVC) begin
          m_vid_pid = pid;
          m_pid_ok[0] = 1'b1;
          if (!m_codec[0]) m_codec = {m_ent_type == ST_HEVC, 1'b1};
        end else if (m_ent_type == ST_AAC) begin
          m_aud_pid = pid;
          m_pid_ok[1] = 1'b1;
        end
        m_ent_start = c + 1 + int'(m_fields[11:0]);
      end
    end
  endfunction

  function automatic void psi_model(logic [7:0] b);
    if (!m_pusi) return;
    case (m_psi)
      PSI_POINTER: begin
        m_skip = b;
        m_psi = (b != 0) ? PSI_SKIP : PSI_SECTION;
        m_sec_cur = 0; m_sec_ok = 1; m_sec_len = 0; m_cur_next = 0;
        m_pil = 0; m_ent_start = 'hffff; m_fields = '0;
      end
      PSI_SKIP: begin
        m_skip = m_skip - 8'd1;
        if (m_skip == 0) m_psi = PSI_SECTION;
      end
      default: begin
        if (m_sec_ok != 0) begin
          section_model(b);
          if (m_sec_cur < 4095) m_sec_cur++;
        end
      end
    endcase
  endfunction

  function automatic void pes_model(logic [7:0] b);
    int unsigned s, c, h;
    s = (m_tgt == TGT_AUD);
    if (m_pes_drop) return;
    if (m_pes_hdr) begin
      c = m_pes_cur;
      if ((c < 2 && b != 0) || (c == 2 && b != 1)) begin
        m_drop = 1;
        push_result(KIND_ERROR, ERR_PES_START, s[0], 0, '0, '0, '0, 0);
        return;
      end
      if (c == 3) begin
        if (b == SID_PADDING) begin
          m_pes_drop = 1;
          return;
        end
        if (b == SID_PSM || b == SID_PRIVATE2 || b == SID_ECM || b == SID_EMM ||
            b == SID_DIRECTORY) begin
          m_pes_special = 1;
          m_hdr_end = 6;
        end
      end
      if (!m_pes_special) begin
        if (c == 7) m_pes_flags = b[7:6];
        if (c == 8) m_hdr_end = 9 + int'(b);
        if (c >= 9 && c <= 18) m_tbuf[c - 9] = b;
      end
      if (m_hdr_end != 0 && c + 1 == m_hdr_end) begin
        if (!m_pes_special) begin
          h = m_hdr_end - 9;
          if (m_pes_flags[1] && h >= 5) m_pts[s] = decode_stamp(0);
          if (m_pes_flags[0]) begin
            if (h >= 10) m_dts[s] = decode_stamp(5);
          end else begin
            m_dts[s] = m_pts[s];
          end
        end
        m_unit_ok[s] = 1;
        m_first[s] = 1;
        m_pes_hdr = 0;
      end
      if (m_pes_cur < 255) m_pes_cur++;
      return;
    end
    if (!m_unit_ok[s]) return;
    push_result(KIND_ES, ERR_NONE, s[0], m_first[s], b, m_pts[s], m_dts[s], m_codec[1]);
    m_first[s] = 0;
  endfunction

  function automatic void body_model(logic [7:0] b);
    case (m_phase)
      PH_ALEN: begin
        m_skip = b;
        if (b == 0) begin
          if (m_afc[0]) open_payload(); else m_phase = PH_NONE;
        end else begin
          m_phase = PH_ASKIP;
        end
      end
      PH_ASKIP: begin
        m_skip = m_skip - 8'd1;
        if (m_skip == 0) begin
          if (m_afc[0]) open_payload(); else m_phase = PH_NONE;
        end
      end
      PH_PAY: begin
        if (m_tgt == TGT_PAT || m_tgt == TGT_PMT) psi_model(b);
        else if (m_tgt == TGT_VID || m_tgt == TGT_AUD) pes_model(b);
      end
      default: ;
    endcase
  endfunction

  function automatic void new_packet();
    m_hdr = 32'(SYNC_BYTE);
    m_drop = 0;
    m_phase = PH_NONE;
    m_tgt = TGT_NONE;
  endfunction

  // Advances the predicted state by one accepted byte.
  function automatic void demux_model(logic [7:0] b);
    int unsigned p;
    logic [12:0] pid;
    p = m_pos;
    if (!m_locked) begin
      if (b == SYNC_BYTE) begin
        m_locked = 1;
        new_packet();
        m_pos = 1;
      end
      return;
    end
    if (p == 0) begin
      if (b != SYNC_BYTE) begin
        m_locked = 0;
        push_result(KIND_ERROR, ERR_SYNC, 0, 0, '0, '0, '0, 0);
        return;
      end
      new_packet();
    end else if (p < 4) begin
      m_hdr = {m_hdr[23:0], b};
      if (p == 1 && b[7]) begin
        m_drop = 1;
        push_result(KIND_ERROR, ERR_TRANSPORT, 0, 0, '0, '0, '0, 0);
      end
      if (p == 3) begin
        pid = m_hdr[20:8];
        m_pusi = m_hdr[22];
        m_afc = b[5:4];
        if (pid == 0) m_tgt = TGT_PAT;
        else if (m_pmt_ok && pid == m_pmt_pid) m_tgt = TGT_PMT;
        else if (m_pid_ok[0] && pid == m_vid_pid) m_tgt = TGT_VID;
        else if (m_pid_ok[1] && pid == m_aud_pid) m_tgt = TGT_AUD;
        else m_tgt = TGT_NONE;
        if (m_afc[1]) m_phase = PH_ALEN;
        else if (m_afc[0]) open_payload();
        else m_phase = PH_NONE;
      end
    end else if (!m_drop && p < PKT_LEN) begin
      body_model(b);
    end
    m_pos = (p + 1 >= PKT_LEN) ? 0 : p + 1;
  endfunction

  // Sends one byte, idling first at the sender's rate.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    demux_model(b);
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    while (pkt_q.size() < PKT_LEN) add_byte(8'($urandom_range(0, 255)));
    foreach (pkt_q[i]) send_byte(pkt_q[i]);
    pkt_q.delete();
  endtask

  function automatic void put_header(bit tei, bit pusi, logic [12:0] pid, logic [1:0] afc);
    add_byte(SYNC_BYTE);
    add_byte({tei, pusi, 1'b0, pid[12:8]});
    add_byte(pid[7:0]);
    add_byte({2'b00, afc, s_cc});
    s_cc++;
  endfunction

  function automatic void pad_ff();
    while (pkt_q.size() < PKT_LEN) add_byte(8'hff);
  endfunction

  function automatic void build_pat(logic [15:0] prog, bit current);
    int unsigned n, slot, len;
    logic [15:0] p;
    n = $urandom_range(1, 4);
    slot = $urandom_range(0, n - 1);
    len = 5 + 4 * n + 4;
    put_header(0, 1, '0, 2'b01);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte({4'hb, 4'(len >> 8)});
    add_byte(8'(len));
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte({7'h60, current});
    add_byte(8'h00);
    add_byte(8'h00);
    for (int i = 0; i < n; i++) begin
      p = (i == slot) ? prog : 16'($urandom_range(0, 65535));
      add_byte(p[15:8]);
      add_byte(p[7:0]);
      add_byte({3'b111, (i == slot) ? s_pmt_pid[12:8] : 5'($urandom_range(0, 31))});
      add_byte((i == slot) ? s_pmt_pid[7:0] : 8'($urandom_range(0, 255)));
    end
    repeat (4) add_byte(8'($urandom_range(0, 255)));
    pad_ff();
  endfunction

  function automatic void build_pmt();
    logic [7:0] types [3];
    int unsigned pil, len, eil [3];
    logic [12:0] pid;
    types[0] = ($urandom_range(0, 1) != 0) ? ST_HEVC : ST_AVC;
    types[1] = ST_AAC;
    types[2] = 8'($urandom_range(0, 255));
    pil = $urandom_range(0, 6);
    len = 9 + pil + 4;
    for (int i = 0; i < 3; i++) begin
      eil[i] = $urandom_range(0, 5);
      len += 5 + eil[i];
    end
    put_header(0, 1, s_pmt_pid, 2'b01);
    add_byte(8'h00);
    add_byte(8'h02);
    add_byte({4'hb, 4'(len >> 8)});
    add_byte(8'(len));
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(8'hc1);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'he1);
    add_byte(8'h00);
    add_byte({4'hf, 4'(pil >> 8)});
    add_byte(8'(pil));
    repeat (pil) add_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < 3; i++) begin
      pid = (i == 0) ? s_vid_pid : (i == 1) ? s_aud_pid : 13'($urandom_range(32, 8190));
      add_byte(types[i]);
      add_byte({3'b111, pid[12:8]});
      add_byte(pid[7:0]);
      add_byte({4'hf, 4'(eil[i] >> 8)});
      add_byte(8'(eil[i]));
      repeat (eil[i]) add_byte(8'($urandom_range(0, 255)));
    end
    repeat (4) add_byte(8'($urandom_range(0, 255)));
    pad_ff();
  endfunction

  // PES packet on pid; a unit start carries a header with random stamps.
  function automatic void build_pes(logic [12:0] pid, bit unit, logic [7:0] sid);
    logic [1:0] flags, afc;
    int unsigned hlen, alen;
    afc = ($urandom_range(0, 3) == 0) ? 2'b11 : 2'b01;
    put_header(0, unit, pid, afc);
    if (afc[1]) begin
      alen = $urandom_range(0, 20);
      add_byte(8'(alen));
      repeat (alen) add_byte(8'($urandom_range(0, 255)));
    end
    if (!unit) return;
    case ($urandom_range(0, 19))
      0: add_byte(8'($urandom_range(1, 255)));
      1: begin
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'($urandom_range(2, 255)));
      end
      default: begin
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h01);
      end
    endcase
    add_byte(sid);
    add_byte(8'h00);
    add_byte(8'h00);
    flags = 2'($urandom_range(0, 3));
    hlen = (flags == 2'b11) ? 10 : (flags == 2'b10) ? 5 : $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) hlen = $urandom_range(0, 255);
    add_byte(8'h80);
    add_byte({flags, 6'd0});
    add_byte(8'(hlen));
    repeat (hlen) if (pkt_q.size() < PKT_LEN) add_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] pick_sid(bit audio);
    case ($urandom_range(0, 15))
      0: return SID_PADDING;
      1: return SID_PSM;
      2: return SID_PRIVATE2;
      3: return SID_ECM;
      4: return SID_EMM;
      5: return SID_DIRECTORY;
      default: return audio ? 8'hc0 : 8'he0;
    endcase
  endfunction

  // Junk without sync bytes, so the hunt ends at the next packet.
  task automatic send_junk(int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == SYNC_BYTE) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic write_program(input logic [15:0] prog);
    wanted_program_we_i <= 1'b1;
    wanted_program_i <= prog;
    @(posedge clk_i);
    m_want = prog;
    @(negedge clk_i);
    wanted_program_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_out_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Hunting for sync, then learning the PMT pid and the stream pids from the tables.
  task automatic test_tables(input logic [15:0] prog);
    write_program(prog);
    s_pmt_pid = 13'($urandom_range(16, 8190));
    s_vid_pid = 13'($urandom_range(16, 8190));
    s_aud_pid = 13'($urandom_range(16, 8190));
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h12);
    build_pat(prog, 1);
    send_packet();
    build_pmt();
    send_packet();
    wait_idle();
  endtask

  // One PES unit on the video pid and one on the audio pid.
  task automatic test_pes();
    build_pes(s_vid_pid, 1, 8'he0);
    send_packet();
    build_pes(s_aud_pid, 1, pick_sid(1));
    send_packet();
    wait_idle();
  endtask

  // A bad sync byte at a packet start, then a new lock on a packet with the error flag.
  task automatic test_errors();
    send_byte(8'hb8);
    send_junk(5);
    put_header(1, 0, s_vid_pid, 2'b01);
    foreach (pkt_q[i]) send_byte(pkt_q[i]);
    pkt_q.delete();
    wait_idle();
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);

  always @(posedge clk_i) begin
    demux_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_out_q.size() == 0) begin
        report("result with none expected");
      end else begin
        want = pending_out_q.pop_front();
        if (kind_o !== want.kind) report($sformatf("kind %0d exp %0d", kind_o, want.kind));
        if (error_code_o !== want.err)
          report($sformatf("error_code %0d exp %0d", error_code_o, want.err));
        if (is_audio_o !== want.aud)
          report($sformatf("is_audio %0d exp %0d", is_audio_o, want.aud));
        if (unit_start_o !== want.first)
          report($sformatf("unit_start %0d exp %0d", unit_start_o, want.first));
        if (es_byte_o !== want.data)
          report($sformatf("es_byte %h exp %h", es_byte_o, want.data));
        if (pts_o !== want.pts) report($sformatf("pts %h exp %h", pts_o, want.pts));
        if (dts_o !== want.dts) report($sformatf("dts %h exp %h", dts_o, want.dts));
        if (video_is_hevc_o !== want.hevc)
          report($sformatf("video_is_hevc %0d exp %0d", video_is_hevc_o, want.hevc));
      end
    end
  end

  // Ends the run when neither side moves an item for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    model_reset();
    tx_idle_pct = 6;
    rx_idle_pct = 54;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_tables(16'($urandom_range(0, 65535)));
    tx_idle_pct = 54;
    rx_idle_pct = 6;
    test_pes();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_errors();
    if (fail_count == 0 && pending_out_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[ts_pid_filter_pes_demux.f]
rtl/core/tspd_pkg.sv
rtl/core/ts_pid_filter_pes_demux.sv
dv/ts_pid_filter_pes_demux_tb.sv
